// ===== rtl/core/mnps_pkg.sv =====
// ----------------------------------------------------------------------------
// mnps_pkg: shared types and constants for the mono note priority selector
// Note table size, priority mode codes, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mnps_pkg;

    localparam int NOTE_COUNT = 128;
    localparam int IDX_W      = $clog2(NOTE_COUNT);
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int TIME_W     = 32;
    localparam int MODE_W     = 2;

    localparam logic [NOTE_W:0] NOTE_LIMIT = (NOTE_W + 1)'(NOTE_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NOTE_COUNT - 1);

    // Priority mode codes; the unused code falls back to highest note
    localparam logic [MODE_W-1:0] MODE_HIGHEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOWEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOUDEST = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;   // transaction accepted: update note set, restart scan
        logic issue;   // read the entry under the scan counter and advance
        logic load;    // move the chosen note into the output register
    } cmd_t;

    typedef struct packed {
        logic scan_last;   // scan counter sits on the last entry
        logic has_change;  // a note sounds and differs from the last one sent
        logic out_free;    // output register can take a new result
    } stat_t;

endpackage

// ===== rtl/core/mnps_ram.sv =====
// ----------------------------------------------------------------------------
// mnps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/mnps_datapath.sv =====
// ----------------------------------------------------------------------------
// mnps_datapath: note set, scan compare and output register
// Holds the sounding flags and the velocity RAM, walks the entries under
// controller command and keeps the best candidate and the last sent note.
// ----------------------------------------------------------------------------
module mnps_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mnps_pkg::cmd_t                      cmd,
    output mnps_pkg::stat_t                     stat,
    input  logic [mnps_pkg::NOTE_W-1:0]         note_number,
    input  logic                                is_note_on,
    input  logic [mnps_pkg::VEL_W-1:0]          note_velocity,
    input  logic [mnps_pkg::TIME_W-1:0]         event_time,
    input  logic                                cfg_write_en,
    input  logic [mnps_pkg::MODE_W-1:0]         cfg_write_data,
    output logic                                pick_valid,
    input  logic                                pick_ready,
    output logic [mnps_pkg::NOTE_W-1:0]         chosen_note,
    output logic [mnps_pkg::TIME_W-1:0]         change_time
);

    logic [mnps_pkg::MODE_W-1:0]     mode_reg;
    logic [mnps_pkg::NOTE_COUNT-1:0] active_reg;
    logic [mnps_pkg::TIME_W-1:0]     time_reg;
    logic [mnps_pkg::IDX_W-1:0]      scan_reg;
    logic                            cmp_en_reg;
    logic [mnps_pkg::IDX_W-1:0]      cmp_idx_reg;
    logic                            found_reg;
    logic                            found_next;
    logic [mnps_pkg::IDX_W-1:0]      best_reg;
    logic [mnps_pkg::IDX_W-1:0]      best_next;
    logic [mnps_pkg::VEL_W-1:0]      best_loud_reg;
    logic [mnps_pkg::VEL_W-1:0]      best_loud_next;
    logic [mnps_pkg::NOTE_W-1:0]     last_reg;
    logic                            last_valid_reg;
    logic                            out_valid_reg;
    logic [mnps_pkg::NOTE_W-1:0]     out_note_reg;
    logic [mnps_pkg::TIME_W-1:0]     out_time_reg;

    logic                            in_range;
    logic [mnps_pkg::IDX_W-1:0]      wr_idx;
    logic [mnps_pkg::VEL_W-1:0]      loud;
    logic                            cand_active;
    logic [mnps_pkg::NOTE_W-1:0]     best_note;

    assign in_range = {1'b0, note_number} < mnps_pkg::NOTE_LIMIT;
    assign wr_idx   = note_number[mnps_pkg::IDX_W-1:0];

    mnps_ram #(
        .WIDTH (mnps_pkg::VEL_W),
        .DEPTH (mnps_pkg::NOTE_COUNT)
    ) u_loud_ram (
        .clk     (clk),
        .wr_en   (cmd.start && in_range && is_note_on),
        .wr_addr (wr_idx),
        .wr_data (note_velocity),
        .rd_en   (cmd.issue),
        .rd_addr (scan_reg),
        .rd_data (loud)
    );

    assign cand_active = active_reg[cmp_idx_reg];

    // Compare the entry whose velocity just came out of the RAM
    always_comb
    begin
        found_next     = found_reg;
        best_next      = best_reg;
        best_loud_next = best_loud_reg;
        if (cmp_en_reg && cand_active)
        begin
            found_next = 1'b1;
            unique case (mode_reg)
                mnps_pkg::MODE_LOWEST:
                begin
                    if (!found_reg)
                    begin
                        best_next = cmp_idx_reg;
                    end
                end
                mnps_pkg::MODE_LOUDEST:
                begin
                    if (!found_reg || (loud > best_loud_reg))
                    begin
                        best_next      = cmp_idx_reg;
                        best_loud_next = loud;
                    end
                end
                default:
                begin
                    best_next = cmp_idx_reg;
                end
            endcase
        end
    end

    assign best_note = mnps_pkg::NOTE_W'(best_reg);

    assign stat.scan_last  = (scan_reg == mnps_pkg::LAST_IDX);
    assign stat.has_change = found_reg && !(last_valid_reg && (last_reg == best_note));
    assign stat.out_free   = !out_valid_reg || pick_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= mnps_pkg::MODE_HIGHEST;
            active_reg     <= '0;
            scan_reg       <= '0;
            cmp_en_reg     <= 1'b0;
            found_reg      <= 1'b0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            cmp_en_reg <= cmd.issue;
            if (cmd.start)
            begin
                if (in_range)
                begin
                    active_reg[wr_idx] <= is_note_on;
                end
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                found_reg <= found_next;
                if (cmd.issue)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (cmd.load)
            begin
                out_valid_reg  <= 1'b1;
                last_reg       <= best_note;
                last_valid_reg <= 1'b1;
            end
            else if (pick_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            time_reg <= event_time;
        end
        cmp_idx_reg   <= scan_reg;
        best_reg      <= best_next;
        best_loud_reg <= best_loud_next;
        if (cmd.load)
        begin
            out_note_reg <= best_note;
            out_time_reg <= time_reg;
        end
    end

    assign pick_valid  = out_valid_reg;
    assign chosen_note = out_note_reg;
    assign change_time = out_time_reg;

endmodule

// ===== rtl/core/mnps_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnps_ctrl: sequencing state machine
// Accepts one transaction, runs the scan over all note entries, then hands
// a changed choice to the output register.
// ----------------------------------------------------------------------------
module mnps_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            note_valid,
    output logic            note_ready,
    input  mnps_pkg::stat_t stat,
    output mnps_pkg::cmd_t  cmd
);

    mnps_pkg::state_t state_reg;
    mnps_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mnps_pkg::ST_IDLE:
            begin
                if (note_valid)
                begin
                    state_next = mnps_pkg::ST_SCAN;
                end
            end
            mnps_pkg::ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = mnps_pkg::ST_DRAIN;
                end
            end
            mnps_pkg::ST_DRAIN:
            begin
                state_next = mnps_pkg::ST_EMIT;
            end
            mnps_pkg::ST_EMIT:
            begin
                // drop an unchanged choice, hold a changed one until the slot frees
                if (!stat.has_change || stat.out_free)
                begin
                    state_next = mnps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mnps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        note_ready = (state_reg == mnps_pkg::ST_IDLE);
        cmd.start  = (state_reg == mnps_pkg::ST_IDLE) && note_valid;
        cmd.issue  = (state_reg == mnps_pkg::ST_SCAN);
        cmd.load   = (state_reg == mnps_pkg::ST_EMIT) && stat.has_change && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mnps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/mono_note_priority_selector_unit.sv =====
// ----------------------------------------------------------------------------
// mono_note_priority_selector_unit: monophonic note priority selector
// Keeps the set of sounding notes and sends the selected note (highest,
// lowest or loudest) whenever the selection changes.
//
//   channel   direction  handshake                 payload
//   note      in         note_valid / note_ready   note_number, is_note_on,
//                                                   note_velocity, event_time
//   pick      out        pick_valid / pick_ready   chosen_note, change_time
//   cfg       in         cfg_write_en              cfg_write_data (priority mode)
//
// A transaction steps through accept, the scan of every entry of the velocity
// RAM, a drain step for the registered read and a decide step. The scan reads
// the entries one at a time through the single RAM read port.
// Reset clears the sounding flags, the last sent note and the mode; the
// velocity RAM is not cleared. A result waiting in the output register does
// not block the next transaction; only the decide cycle waits on pick_ready.
// ----------------------------------------------------------------------------
module mono_note_priority_selector_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        note_valid,
    output logic                        note_ready,
    input  logic [mnps_pkg::NOTE_W-1:0] note_number,
    input  logic                        is_note_on,
    input  logic [mnps_pkg::VEL_W-1:0]  note_velocity,
    input  logic [mnps_pkg::TIME_W-1:0] event_time,
    output logic                        pick_valid,
    input  logic                        pick_ready,
    output logic [mnps_pkg::NOTE_W-1:0] chosen_note,
    output logic [mnps_pkg::TIME_W-1:0] change_time,
    input  logic                        cfg_write_en,
    input  logic [mnps_pkg::MODE_W-1:0] cfg_write_data
);

    mnps_pkg::cmd_t  cmd;
    mnps_pkg::stat_t stat;

    mnps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .note_valid (note_valid),
        .note_ready (note_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    mnps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .note_number    (note_number),
        .is_note_on     (is_note_on),
        .note_velocity  (note_velocity),
        .event_time     (event_time),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .pick_valid     (pick_valid),
        .pick_ready     (pick_ready),
        .chosen_note    (chosen_note),
        .change_time    (change_time)
    );

endmodule

// ===== rtl/core/mnps_checker.sv =====
// ----------------------------------------------------------------------------
// mnps_checker: port-level checks for the selector
// Watches the top-level ports and flags sequencing and output slips.
// ----------------------------------------------------------------------------
module mnps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        note_valid,
    input logic                        note_ready,
    input logic                        pick_valid,
    input logic                        pick_ready,
    input logic [mnps_pkg::NOTE_W-1:0] chosen_note,
    input logic [mnps_pkg::TIME_W-1:0] change_time
);

    // The scan keeps the input closed right after a transaction
    a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (note_valid && note_ready) |=> !note_ready)
        else $error("input ready right after a transaction");

    // A new result is loaded only from the decide step, never from idle
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pick_valid) |-> !$past(note_ready))
        else $error("result appeared without a completed scan");

    // Hold a stalled result
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid && !pick_ready) |=>
            (pick_valid && $stable(chosen_note) && $stable(change_time)))
        else $error("stalled result changed or dropped");

    // Two back-to-back results never repeat the same note
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid && pick_ready) |=> !(pick_valid && $past(pick_valid)
            && !$stable(change_time) && $stable(chosen_note)))
        else $error("same note sent twice in a row");

endmodule

bind mono_note_priority_selector_unit mnps_checker u_mnps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .note_valid  (note_valid),
    .note_ready  (note_ready),
    .pick_valid  (pick_valid),
    .pick_ready  (pick_ready),
    .chosen_note (chosen_note),
    .change_time (change_time)
);
